/* design/flash_sector_write_back_cache_unit_assert.svh */
// Assertion macros for the flash sector write-back cache.
// Included by the top level; relies on clk and arst_n in the including scope.
`ifndef FLASH_SECTOR_WRITE_BACK_CACHE_UNIT_ASSERT_SVH
`define FLASH_SECTOR_WRITE_BACK_CACHE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSWBC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cache assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FSWBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cache assertion failed");

`endif

/* design/fswbc_pkg.sv */
// Shared types, constants and the CRC-32 byte step of the flash sector cache.
// No dependencies.
package fswbc_pkg;

	localparam int ADDR_W = 14;
	localparam int DATA_W = 8;
	localparam int TOTAL_W = 32;
	localparam int CRC_W = 32;

	localparam int PAYLOAD_BYTES_DEF = 252;
	localparam int NUM_SECTORS_DEF = 64;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

	localparam logic [1:0] FUNC_READ = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_FLUSH = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] logical_address;
		logic [DATA_W-1:0] write_data;
		logic              last_byte;
		logic              sync;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic               hit;
		logic               crc_error;
		logic               flushed;
		logic [TOTAL_W-1:0] hit_total;
		logic [TOTAL_W-1:0] miss_total;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX,
		ST_DECIDE,
		ST_WB,
		ST_LOAD,
		ST_ACCESS,
		ST_RDWAIT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load_req;
		logic do_div;
		logic do_fix;
		logic cnt_clr;
		logic wb_step;
		logic wb_done;
		logic ld_step;
		logic ld_done;
		logic count_hit;
		logic count_miss;
		logic acc_read;
		logic acc_write;
		logic cap_rdata;
		logic rsp_push;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       in_range;
		logic       hit;
		logic       valid;
		logic       dirty;
		logic       last_sync;
		logic       cnt_end;
		logic       rsp_free;
	} sts_t;

	// One byte of the reflected CRC-32, eight bit steps.
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
		input logic [DATA_W-1:0] data);
		logic [CRC_W-1:0] c;
		c = crc ^ {{(CRC_W-DATA_W){1'b0}}, data};
		for (int b = 0; b < DATA_W; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* design/fswbc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fswbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* design/fswbc_ctrl.sv */
// Controller state machine of the flash sector cache.
// Depends on fswbc_pkg; drives the datapath through cmd_t and reads sts_t.
module fswbc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  fswbc_pkg::sts_t  sts,
	output fswbc_pkg::cmd_t  cmd
);

	fswbc_pkg::state_t state_q, state_d;
	logic then_load_q, then_load_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fswbc_pkg::ST_IDLE;
			then_load_q <= 1'b0;
		end else begin
			state_q <= state_d;
			then_load_q <= then_load_d;
		end
	end

	always_comb begin
		state_d = state_q;
		then_load_d = then_load_q;
		cmd = '0;
		req_stall = (state_q != fswbc_pkg::ST_IDLE);
		unique case (state_q)
			fswbc_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d = fswbc_pkg::ST_DIV;
				end
			end
			fswbc_pkg::ST_DIV: begin
				cmd.do_div = 1'b1;
				state_d = fswbc_pkg::ST_FIX;
			end
			fswbc_pkg::ST_FIX: begin
				cmd.do_fix = 1'b1;
				state_d = fswbc_pkg::ST_DECIDE;
			end
			fswbc_pkg::ST_DECIDE: begin
				priority if (sts.func == fswbc_pkg::FUNC_FLUSH) begin
					if (sts.valid) begin
						cmd.cnt_clr = 1'b1;
						then_load_d = 1'b0;
						state_d = fswbc_pkg::ST_WB;
					end else begin
						state_d = fswbc_pkg::ST_RESP;
					end
				end else if ((sts.func == fswbc_pkg::FUNC_READ ||
					sts.func == fswbc_pkg::FUNC_WRITE) && sts.in_range) begin
					if (sts.hit) begin
						cmd.count_hit = 1'b1;
						state_d = fswbc_pkg::ST_ACCESS;
					end else begin
						cmd.count_miss = 1'b1;
						cmd.cnt_clr = 1'b1;
						if (sts.valid && sts.dirty) begin
							then_load_d = 1'b1;
							state_d = fswbc_pkg::ST_WB;
						end else begin
							state_d = fswbc_pkg::ST_LOAD;
						end
					end
				end else begin
					state_d = fswbc_pkg::ST_RESP;
				end
			end
			fswbc_pkg::ST_WB: begin
				cmd.wb_step = 1'b1;
				if (sts.cnt_end) begin
					cmd.wb_done = 1'b1;
					if (then_load_q) begin
						cmd.cnt_clr = 1'b1;
						state_d = fswbc_pkg::ST_LOAD;
					end else begin
						state_d = fswbc_pkg::ST_RESP;
					end
				end
			end
			fswbc_pkg::ST_LOAD: begin
				cmd.ld_step = 1'b1;
				if (sts.cnt_end) begin
					cmd.ld_done = 1'b1;
					state_d = fswbc_pkg::ST_ACCESS;
				end
			end
			fswbc_pkg::ST_ACCESS: begin
				if (sts.func == fswbc_pkg::FUNC_READ) begin
					cmd.acc_read = 1'b1;
					state_d = fswbc_pkg::ST_RDWAIT;
				end else begin
					cmd.acc_write = 1'b1;
					if (sts.last_sync) begin
						cmd.cnt_clr = 1'b1;
						then_load_d = 1'b0;
						state_d = fswbc_pkg::ST_WB;
					end else begin
						state_d = fswbc_pkg::ST_RESP;
					end
				end
			end
			fswbc_pkg::ST_RDWAIT: begin
				cmd.cap_rdata = 1'b1;
				state_d = fswbc_pkg::ST_RESP;
			end
			fswbc_pkg::ST_RESP: begin
				if (sts.rsp_free) begin
					cmd.rsp_push = 1'b1;
					state_d = fswbc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fswbc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* design/fswbc_dpath.sv */
// Datapath of the flash sector cache: address split, sector buffer, flash
// arrays, CRC-32 engine, counters and the result register. Uses fswbc_pkg, fswbc_ram.
module fswbc_dpath #(
	parameter int PAYLOAD_BYTES = fswbc_pkg::PAYLOAD_BYTES_DEF,
	parameter int NUM_SECTORS = fswbc_pkg::NUM_SECTORS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fswbc_pkg::req_t  req,
	input  fswbc_pkg::cmd_t  cmd,
	output fswbc_pkg::sts_t  sts,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output fswbc_pkg::rsp_t  rsp
);

	localparam int AW = fswbc_pkg::ADDR_W;
	localparam int DW = fswbc_pkg::DATA_W;
	localparam int CW = fswbc_pkg::CRC_W;
	localparam int TW = fswbc_pkg::TOTAL_W;
	localparam int OFF_W = PAYLOAD_BYTES > 1 ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
	localparam int SEC_W = NUM_SECTORS > 1 ? $clog2(NUM_SECTORS) : 1;
	localparam int FLASH_DEPTH = NUM_SECTORS * PAYLOAD_BYTES;
	localparam int FA_W = FLASH_DEPTH > 1 ? $clog2(FLASH_DEPTH) : 1;
	localparam int PW = $clog2(PAYLOAD_BYTES) + 1;
	localparam int K = AW + PW;
	localparam logic [K-1:0] RECIP = K'((64'd1 << K) / PAYLOAD_BYTES);

	fswbc_pkg::req_t req_q;
	logic [AW-1:0]    qest_q;
	logic [AW-1:0]    sector_q;
	logic [OFF_W-1:0] off_q;
	logic [FA_W-1:0]  base_q;
	logic [SEC_W-1:0] tag_q;
	logic [FA_W-1:0]  tag_base_q;
	logic             valid_q, dirty_q;
	logic [NUM_SECTORS-1:0] written_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    crc_q;
	logic [TW-1:0]    hit_cnt_q, miss_cnt_q;
	logic [DW-1:0]    rdata_q;
	logic             hit_q, crc_err_q, flushed_q;
	logic             rsp_valid_q;
	fswbc_pkg::rsp_t  rsp_q;

	logic [AW+K-1:0]  prod;
	logic [AW-1:0]    qp, rem;
	logic             corr;
	logic [SEC_W-1:0] sec;
	logic             cnt_nz, issue;
	logic [OFF_W-1:0] idx, prev;
	logic [DW-1:0]    buf_rd, flash_rd, ld_byte, crc_in;
	logic [CW-1:0]    ck_rd, stored_ck, crc_nx;
	logic             buf_we, buf_re, flash_we, flash_re;
	logic [OFF_W-1:0] buf_wa, buf_ra;
	logic [DW-1:0]    buf_wd;
	logic [FA_W-1:0]  flash_wa, flash_ra;

	// Address split: reciprocal estimate, then one correction step.
	assign prod = (AW + K)'(req_q.logical_address) * (AW + K)'(RECIP);
	assign qp = AW'(qest_q * PAYLOAD_BYTES);
	assign rem = req_q.logical_address - qp;
	assign corr = (32'(rem) >= PAYLOAD_BYTES);

	assign sec = SEC_W'(sector_q);
	assign cnt_nz = (cnt_q != '0);
	assign issue = (32'(cnt_q) < PAYLOAD_BYTES);
	assign idx = OFF_W'(cnt_q);
	assign prev = OFF_W'(cnt_q - 1'b1);

	assign ld_byte = written_q[sec] ? flash_rd : fswbc_pkg::ERASED_BYTE;
	assign stored_ck = written_q[sec] ? ck_rd : fswbc_pkg::CRC_INIT;
	assign crc_in = cmd.wb_step ? buf_rd : ld_byte;
	assign crc_nx = fswbc_pkg::crc_byte(crc_q, crc_in);

	assign buf_we = (cmd.ld_step && cnt_nz) || cmd.acc_write;
	assign buf_wa = cmd.acc_write ? off_q : prev;
	assign buf_wd = cmd.acc_write ? req_q.write_data : ld_byte;
	assign buf_re = (cmd.wb_step && issue) || cmd.acc_read;
	assign buf_ra = cmd.acc_read ? off_q : idx;

	assign flash_we = cmd.wb_step && cnt_nz;
	assign flash_wa = tag_base_q + FA_W'(cnt_q - 1'b1);
	assign flash_re = cmd.ld_step && issue;
	assign flash_ra = base_q + FA_W'(cnt_q);

	fswbc_ram #(.WIDTH(DW), .DEPTH(PAYLOAD_BYTES)) u_buf (
		.clk     (clk),
		.wr_en   (buf_we),
		.wr_addr (buf_wa),
		.wr_data (buf_wd),
		.rd_en   (buf_re),
		.rd_addr (buf_ra),
		.rd_data (buf_rd)
	);

	fswbc_ram #(.WIDTH(DW), .DEPTH(FLASH_DEPTH)) u_flash (
		.clk     (clk),
		.wr_en   (flash_we),
		.wr_addr (flash_wa),
		.wr_data (buf_rd),
		.rd_en   (flash_re),
		.rd_addr (flash_ra),
		.rd_data (flash_rd)
	);

	fswbc_ram #(.WIDTH(CW), .DEPTH(NUM_SECTORS)) u_cksum (
		.clk     (clk),
		.wr_en   (cmd.wb_done),
		.wr_addr (tag_q),
		.wr_data (~crc_nx),
		.rd_en   (cmd.ld_step),
		.rd_addr (sec),
		.rd_data (ck_rd)
	);

	// Request fields, address split stages and result flags.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
			rdata_q <= '0;
			hit_q <= 1'b0;
			crc_err_q <= 1'b0;
			flushed_q <= 1'b0;
		end
		if (cmd.do_div) begin
			qest_q <= prod[AW+K-1:K];
		end
		if (cmd.do_fix) begin
			sector_q <= qest_q + AW'(corr);
			off_q <= corr ? OFF_W'(rem - AW'(PAYLOAD_BYTES)) : OFF_W'(rem);
			base_q <= FA_W'(qp) + (corr ? FA_W'(PAYLOAD_BYTES) : '0);
		end
		if (cmd.count_hit) begin
			hit_q <= 1'b1;
		end
		if (cmd.wb_done) begin
			flushed_q <= 1'b1;
		end
		if (cmd.ld_done) begin
			crc_err_q <= (~crc_nx != stored_ck);
		end
		if (cmd.cap_rdata) begin
			rdata_q <= buf_rd;
		end
		if (cmd.cnt_clr) begin
			crc_q <= fswbc_pkg::CRC_INIT;
		end else if ((cmd.wb_step || cmd.ld_step) && cnt_nz) begin
			crc_q <= crc_nx;
		end
		if (cmd.rsp_push) begin
			rsp_q.read_data <= rdata_q;
			rsp_q.hit <= hit_q;
			rsp_q.crc_error <= crc_err_q;
			rsp_q.flushed <= flushed_q;
			rsp_q.hit_total <= hit_cnt_q;
			rsp_q.miss_total <= miss_cnt_q;
		end
	end

	// Buffer tag, marks, per-sector written bits, counters and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
			tag_base_q <= '0;
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			written_q <= '0;
			cnt_q <= '0;
			hit_cnt_q <= '0;
			miss_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.wb_step || cmd.ld_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.count_hit) begin
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end
			if (cmd.count_miss) begin
				miss_cnt_q <= miss_cnt_q + 1'b1;
			end
			if (cmd.wb_done) begin
				written_q[tag_q] <= 1'b1;
				dirty_q <= 1'b0;
			end
			if (cmd.ld_done) begin
				tag_q <= sec;
				tag_base_q <= base_q;
				valid_q <= 1'b1;
				dirty_q <= 1'b0;
			end
			if (cmd.acc_write) begin
				dirty_q <= 1'b1;
			end
			if (cmd.rsp_push) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.func = req_q.func;
	assign sts.in_range = (32'(sector_q) < NUM_SECTORS);
	assign sts.hit = valid_q && (tag_q == sec);
	assign sts.valid = valid_q;
	assign sts.dirty = dirty_q;
	assign sts.last_sync = req_q.last_byte && req_q.sync;
	assign sts.cnt_end = (32'(cnt_q) == PAYLOAD_BYTES);
	assign sts.rsp_free = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

/* design/flash_sector_write_back_cache_unit.sv */
// Top level of the single-sector write-back flash cache with CRC-32 checked sectors.
// Depends on fswbc_pkg, fswbc_ctrl, fswbc_dpath and the assertion macro header.
//
// Usage: one request is a one-byte access (read, write or flush) on the req channel
// (req_valid, req_stall, req). Each accepted request yields exactly one result on
// the rsp channel (rsp_valid, rsp_stall, rsp), in request order.
// The block works on one request at a time: req_stall is high from the cycle after
// a request is accepted until its result has been placed in the output register.
// Requests that do nothing (bad address, unused code, flush of an empty buffer)
// and plain hits walk no sector. A miss adds one sector walk to load the new
// sector, and before it a second walk to write back the buffered sector if it
// is dirty. A flush of a valid buffer, or a write with last_byte and sync, walks
// the buffer once for the write-back. The walks are set by the single read port
// of the sector buffer and of the flash array, one byte per cycle, with the CRC-32
// updated one byte per cycle alongside.
// Reset empties the buffer, clears both totals and marks every flash sector as
// erased (0xFF payload, 0xFFFFFFFF checksum) through per-sector written bits, so
// no clearing pass is needed and requests are taken right after reset.
// If the receiver holds rsp_stall, the result stays in the output register; the
// next request is still accepted and worked on, and only its own result waits.
`include "flash_sector_write_back_cache_unit_assert.svh"

module flash_sector_write_back_cache_unit #(
	parameter int PAYLOAD_BYTES = fswbc_pkg::PAYLOAD_BYTES_DEF,
	parameter int NUM_SECTORS = fswbc_pkg::NUM_SECTORS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  fswbc_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output fswbc_pkg::rsp_t  rsp
);

	fswbc_pkg::cmd_t cmd;
	fswbc_pkg::sts_t sts;

	// The controller sequences the access; all storage sits in the datapath.
	fswbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fswbc_dpath #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES),
		.NUM_SECTORS   (NUM_SECTORS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Once a request is taken, the block is busy in the next cycle.
	`FSWBC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
	// A hit never loads a sector, so it can never report a CRC failure.
	`FSWBC_ASSERT_NOW(a_hit_no_crc, rsp_valid && rsp.hit, !rsp.crc_error)
	// A completed load leaves the buffer valid and clean.
	`FSWBC_ASSERT_NEXT(a_load_clean, cmd.ld_done, sts.valid && !sts.dirty)

endmodule
